// ===== rtl/string_to_unsigned_integer_macros.svh =====
// Assertion macros for the string parser.
// Needs clk and arst_n in the scope that uses them.
`ifndef STRING_TO_UNSIGNED_INTEGER_MACROS_SVH
`define STRING_TO_UNSIGNED_INTEGER_MACROS_SVH

// same-cycle implication
`define S2U_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("parser check failed");

// next-cycle implication
`define S2U_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("parser check failed");

`endif

// ===== rtl/s2u_pkg.sv =====
// Shared types and constants for the string to unsigned integer parser.
// No dependencies.
`timescale 1ns / 1ps

package s2u_pkg;

	localparam int VALUE_BITS  = 32;
	localparam int OFFSET_BITS = 16;
	localparam int BASE_BITS   = 5;
	localparam int PROD_BITS   = VALUE_BITS + BASE_BITS;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF_LO = 8'h66;
	localparam logic [7:0] CH_LX    = 8'h78;

	localparam logic [BASE_BITS-1:0] BASE_AUTO = BASE_BITS'(0);
	localparam logic [BASE_BITS-1:0] BASE_OCT  = BASE_BITS'(8);
	localparam logic [BASE_BITS-1:0] BASE_DEC  = BASE_BITS'(10);
	localparam logic [BASE_BITS-1:0] BASE_HEX  = BASE_BITS'(16);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEAD,
		PH_SIGNED,
		PH_ZERO,
		PH_HEXPFX,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	typedef struct packed {
		phase_t                 phase;
		logic [VALUE_BITS-1:0]  acc;
		logic                   neg;
		logic [BASE_BITS-1:0]   base;
		logic [OFFSET_BITS-1:0] offset;
	} parse_state_t;

	typedef struct packed {
		logic                   valid;
		logic [VALUE_BITS-1:0]  value;
		logic [OFFSET_BITS-1:0] offset;
	} parse_result_t;

endpackage

// ===== rtl/s2u_step.sv =====
// One character step of the parser: next parse state and end-of-string result.
// Pure combinational; uses s2u_pkg.
`timescale 1ns / 1ps

module s2u_step
	import s2u_pkg::*;
(
	input  logic [7:0]           char_code,
	input  logic                 string_start,
	input  logic [BASE_BITS-1:0] radix,
	input  parse_state_t         cur_state,
	output parse_state_t         nxt_state,
	output parse_result_t        result
);

	parse_state_t           st;
	logic                   is_ws;
	logic                   is_sign;
	logic                   is_x;
	logic                   is_dec;
	logic                   is_hexl;
	logic                   dhit;
	logic [3:0]             dval;
	logic                   sig_path;
	logic                   zero_lead;
	logic                   take_digit;
	logic                   converted;
	logic [BASE_BITS-1:0]   base_use;
	logic [PROD_BITS-1:0]   prod;
	logic [OFFSET_BITS-1:0] off_inc;
	logic [VALUE_BITS-1:0]  fin_val;

	always_comb begin
		// a start beat restarts from a fresh state
		st = cur_state;
		if (string_start) begin
			st.phase  = PH_LEAD;
			st.acc    = '0;
			st.neg    = 1'b0;
			st.base   = radix;
			st.offset = '0;
		end

		is_ws   = (char_code == CH_SPACE) || (char_code == CH_TAB) || (char_code == CH_LF) ||
			(char_code == CH_CR) || (char_code == CH_FF) || (char_code == CH_VT);
		is_sign = (char_code == CH_PLUS) || (char_code == CH_MINUS);
		is_x    = (char_code == CH_LX) || (char_code == CH_UX);
		is_dec  = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
		is_hexl = ((char_code >= CH_LA) && (char_code <= CH_LF_LO)) ||
			((char_code >= CH_UA) && (char_code <= CH_UF));
		dhit    = is_dec || is_hexl;
		// letters a..f / A..F have low nibble 1..6
		dval    = is_dec ? char_code[3:0] : char_code[3:0] + 4'd9;

		sig_path  = ((st.phase == PH_LEAD) && !is_ws && !is_sign) || (st.phase == PH_SIGNED);
		zero_lead = (char_code == CH_ZERO) && ((st.base == BASE_AUTO) || (st.base == BASE_HEX));
		base_use  = (sig_path && (st.base == BASE_AUTO)) ? BASE_DEC : st.base;

		take_digit = (sig_path && !zero_lead) || ((st.phase == PH_ZERO) && !is_x) ||
			(st.phase == PH_HEXPFX) || (st.phase == PH_DIGITS);

		prod    = st.acc * PROD_BITS'(base_use);
		off_inc = (st.offset == {OFFSET_BITS{1'b1}}) ? st.offset : st.offset + 1'b1;

		converted = (st.phase == PH_ZERO) || (st.phase == PH_DIGITS);
		fin_val   = converted ? st.acc : '0;
		if (st.neg) begin
			fin_val = '0 - fin_val;
		end

		nxt_state     = st;
		result.valid  = 1'b0;
		result.value  = fin_val;
		result.offset = converted ? st.offset : '0;

		if (st.phase == PH_LEAD && is_ws) begin
			nxt_state.offset = off_inc;
		end else if (st.phase == PH_LEAD && is_sign) begin
			nxt_state.neg    = (char_code == CH_MINUS);
			nxt_state.offset = off_inc;
			nxt_state.phase  = PH_SIGNED;
		end else if (sig_path && zero_lead) begin
			nxt_state.base   = (st.base == BASE_AUTO) ? BASE_OCT : st.base;
			nxt_state.offset = off_inc;
			nxt_state.phase  = PH_ZERO;
		end else if (st.phase == PH_ZERO && is_x) begin
			nxt_state.base   = BASE_HEX;
			nxt_state.offset = off_inc;
			nxt_state.phase  = PH_HEXPFX;
		end else if (take_digit) begin
			nxt_state.base = base_use;
			if (dhit && ({1'b0, dval} < base_use)) begin
				nxt_state.acc    = VALUE_BITS'(prod) + VALUE_BITS'(dval);
				nxt_state.offset = off_inc;
				nxt_state.phase  = PH_DIGITS;
			end else begin
				// NUL or any rejected character ends the string
				nxt_state.phase = PH_DONE;
				result.valid    = 1'b1;
			end
		end
	end

endmodule

// ===== rtl/string_to_unsigned_integer.sv =====
// Streaming strtoul-style parser: one character beat in, a result per ended string.
// Both the input beat and its result are registered. Throughput: one character per
// cycle; the input stage stalls only when it must end a string while a result beat
// still waits in the output register. Reset (arst_n low, async) returns the parser
// to idle with a cleared state; stray characters before a string start are ignored.
// Uses s2u_pkg, s2u_step and string_to_unsigned_integer_macros.svh.
`timescale 1ns / 1ps
`include "string_to_unsigned_integer_macros.svh"

module string_to_unsigned_integer
	import s2u_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             char_code,
	input  logic                   string_start,
	input  logic [BASE_BITS-1:0]   radix,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [VALUE_BITS-1:0]  parsed_value,
	output logic [OFFSET_BITS-1:0] end_offset
);

	logic                   valid_s1;
	logic [7:0]             char_s1;
	logic                   start_s1;
	logic [BASE_BITS-1:0]   radix_s1;
	parse_state_t           state_q;
	parse_state_t           step_state;
	parse_result_t          step_res;
	logic                   out_valid_q;
	logic [VALUE_BITS-1:0]  value_q;
	logic [OFFSET_BITS-1:0] offset_q;
	logic                   out_free;
	logic                   fire_s1;

	assign out_free = !out_valid_q || out_ready;
	assign fire_s1  = valid_s1 && (!step_res.valid || out_free);
	assign in_ready = !valid_s1 || fire_s1;

	s2u_step u_step (
		.char_code    (char_s1),
		.string_start (start_s1),
		.radix        (radix_s1),
		.cur_state    (state_q),
		.nxt_state    (step_state),
		.result       (step_res)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1  <= char_code;
			start_s1 <= string_start;
			radix_s1 <= radix;
		end
	end

	// parse state advances once per consumed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_IDLE, acc: '0, neg: 1'b0, base: '0, offset: '0};
		end else if (fire_s1) begin
			state_q <= step_state;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire_s1 && step_res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && step_res.valid) begin
			value_q  <= step_res.value;
			offset_q <= step_res.offset;
		end
	end

	assign out_valid    = out_valid_q;
	assign parsed_value = value_q;
	assign end_offset   = offset_q;

	`S2U_ASSERT_NOW(a_stall_cause, valid_s1 && !fire_s1, step_res.valid && out_valid_q && !out_ready)
	`S2U_ASSERT_NEXT(a_result_loads, fire_s1 && step_res.valid, out_valid)
	`S2U_ASSERT_NEXT(a_done_after_end, fire_s1 && step_res.valid, state_q.phase == PH_DONE)
	`S2U_ASSERT_NOW(a_value_needs_offset, out_valid && (parsed_value != '0), end_offset != '0)

endmodule

// ===== bench/tb_string_to_unsigned_integer.sv =====
// Self-checking bench for string_to_unsigned_integer: directed strings and random strings,
// with random gaps on both sides; each result is checked against a local model of the
// parser. Depends on s2u_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_string_to_unsigned_integer;
	import s2u_pkg::*;

	localparam int RANDOM_CHARS   = 1000;
	localparam int IDLE_PCT       = 12;
	localparam int HOLD_CYCLES    = 150;
	localparam int WATCHDOG_LIMIT = 2000;

	localparam logic [7:0] WS_CHARS [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_FF, CH_VT};

	typedef struct packed {
		logic [7:0]           ch;
		logic                 first;
		logic [BASE_BITS-1:0] base;
	} char_beat_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0]  value;
		logic [OFFSET_BITS-1:0] offset;
	} conversion_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [7:0]             char_code = '0;
	logic                   string_start = 1'b0;
	logic [BASE_BITS-1:0]   radix = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic [VALUE_BITS-1:0]  parsed_value;
	logic [OFFSET_BITS-1:0] end_offset;

	char_beat_t  pending_chars[$];
	conversion_t expected_conversions[$];

	int chars_queued = 0;
	int chars_taken  = 0;
	int mismatches   = 0;
	int cycle_no     = 0;
	int quiet_cycles = 0;
	int hold_left    = 0;
	bit char_taken   = 1'b0;
	bit calm;

	// parser model state
	phase_t                 conv_phase  = PH_IDLE;
	logic [VALUE_BITS-1:0]  conv_acc    = '0;
	logic                   conv_neg    = 1'b0;
	logic [BASE_BITS-1:0]   conv_base   = '0;
	logic [OFFSET_BITS-1:0] conv_offset = '0;

	string_to_unsigned_integer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_code   (char_code),
		.string_start(string_start),
		.radix       (radix),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.parsed_value(parsed_value),
		.end_offset  (end_offset)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// no random gaps on either side in this window
	assign calm = cycle_no >= 600 && cycle_no < 900;

	task automatic push_beat(input logic [7:0] ch, input logic first,
			input logic [BASE_BITS-1:0] base);
		pending_chars.push_back('{ch: ch, first: first, base: base});
		chars_queued++;
	endtask

	task automatic queue_string(input logic [BASE_BITS-1:0] base, input string text,
			input logic [7:0] term);
		foreach (text[i])
			push_beat(text[i], i == 0, i == 0 ? base : BASE_BITS'($urandom_range(31)));
		push_beat(term, text.len() == 0, base);
	endtask

	task automatic count_char();
		if (conv_offset != '1)
			conv_offset++;
	endtask

	task automatic digit_or_end(input logic [7:0] ch);
		int d;
		bit converted;
		logic [VALUE_BITS-1:0] v;
		d = -1;
		if (ch >= CH_ZERO && ch <= CH_NINE)
			d = ch - CH_ZERO;
		else if (ch >= CH_LA && ch <= CH_LF_LO)
			d = ch - CH_LA + 10;
		else if (ch >= CH_UA && ch <= CH_UF)
			d = ch - CH_UA + 10;
		if (d < 0 || d >= int'(conv_base)) begin
			// a lone 0x prefix or no digit at all means nothing was converted
			converted = conv_phase inside {PH_ZERO, PH_DIGITS};
			v = converted ? conv_acc : '0;
			if (conv_neg)
				v = -v;
			expected_conversions.push_back('{value: v, offset: converted ? conv_offset : '0});
			conv_phase = PH_DONE;
		end else begin
			conv_acc = conv_acc * VALUE_BITS'(conv_base) + VALUE_BITS'(d);
			count_char();
			conv_phase = PH_DIGITS;
		end
	endtask

	task automatic convert_char(input char_beat_t b);
		if (b.first) begin
			conv_phase  = PH_LEAD;
			conv_acc    = '0;
			conv_neg    = 1'b0;
			conv_base   = b.base;
			conv_offset = '0;
		end
		case (conv_phase)
			PH_LEAD, PH_SIGNED: begin
				if (conv_phase == PH_LEAD &&
						b.ch inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR}) begin
					count_char();
				end else if (conv_phase == PH_LEAD && b.ch inside {CH_PLUS, CH_MINUS}) begin
					conv_neg = b.ch == CH_MINUS;
					count_char();
					conv_phase = PH_SIGNED;
				end else if (b.ch == CH_ZERO && conv_base inside {BASE_AUTO, BASE_HEX}) begin
					if (conv_base == BASE_AUTO)
						conv_base = BASE_OCT;
					count_char();
					conv_phase = PH_ZERO;
				end else begin
					if (conv_base == BASE_AUTO)
						conv_base = BASE_DEC;
					digit_or_end(b.ch);
				end
			end
			PH_ZERO: begin
				if (b.ch inside {CH_LX, CH_UX}) begin
					conv_base = BASE_HEX;
					count_char();
					conv_phase = PH_HEXPFX;
				end else begin
					digit_or_end(b.ch);
				end
			end
			PH_HEXPFX, PH_DIGITS: digit_or_end(b.ch);
			default: ;
		endcase
	endtask

	task automatic flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endtask

	// input side: sample accepted beats and run them through the model
	always @(posedge clk) begin
		char_taken = arst_n && in_valid && in_ready;
		if (char_taken) begin
			convert_char('{ch: char_code, first: string_start, base: radix});
			chars_taken++;
		end
	end

	// driver: new beat only when the line is free or the last beat was taken
	always @(negedge clk) begin : drive
		char_beat_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || char_taken) begin
			if (pending_chars.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
				nxt = pending_chars.pop_front();
				in_valid     <= 1'b1;
				char_code    <= nxt.ch;
				string_start <= nxt.first;
				radix        <= nxt.base;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls plus two long hold-offs that back up the parser
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (cycle_no == 400 || cycle_no == 1100) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES - 1;
		end else begin
			out_ready <= calm || $urandom_range(99) >= IDLE_PCT;
		end
	end

	always @(posedge clk) begin : check
		conversion_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_conversions.size() == 0) begin
				flag_mismatch($sformatf("unexpected result beat: value %h offset %0d",
					parsed_value, end_offset));
			end else begin
				want = expected_conversions.pop_front();
				if (parsed_value !== want.value)
					flag_mismatch($sformatf("parsed_value: expected %h, got %h",
						want.value, parsed_value));
				if (end_offset !== want.offset)
					flag_mismatch($sformatf("end_offset: expected %0d, got %0d",
						want.offset, end_offset));
			end
		end
	end

	always @(posedge clk) begin
		cycle_no++;
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_string_to_unsigned_integer NOT OK");
			$finish;
		end
	end

	initial begin : stimulus
		logic [BASE_BITS-1:0] base;
		logic [7:0] text_chars[$];
		int random_chars;
		int lim;
		int n;
		int d;
		int pick;

		// directed strings
		queue_string(BASE_DEC, "", CH_NUL);
		push_beat(CH_UA, 1'b0, BASE_HEX);
		push_beat(WS_CHARS[0], 1'b1, BASE_AUTO);
		for (int i = 1; i < 6; i++)
			push_beat(WS_CHARS[i], 1'b0, BASE_BITS'($urandom_range(31)));
		push_beat(CH_MINUS, 1'b0, BASE_AUTO);
		push_beat(CH_NUL, 1'b0, BASE_AUTO);
		queue_string(BASE_AUTO, "0x", "g");
		queue_string(BASE_AUTO, "+0", CH_NINE);
		queue_string(BASE_AUTO, "-7", ":");
		queue_string(BASE_HEX, "0XfF", 8'hFF);
		queue_string(BASE_BITS'(31), "FF", CH_NUL);
		queue_string(BASE_BITS'(1), "0", "1");
		// unfinished string dropped by the next start
		push_beat("5", 1'b1, BASE_DEC);
		queue_string(BASE_HEX, "aB", CH_NUL);

		// random strings, mostly well formed, with some noise beats
		random_chars = 0;
		while (random_chars < RANDOM_CHARS) begin
			if ($urandom_range(9) == 0) begin
				push_beat(8'($urandom_range(255)), $urandom_range(7) == 0,
					BASE_BITS'($urandom_range(31)));
				continue;
			end
			text_chars.delete();
			case ($urandom_range(9))
				0, 1, 2: base = BASE_AUTO;
				3:       base = BASE_OCT;
				4, 5:    base = BASE_DEC;
				6:       base = BASE_HEX;
				default: base = BASE_BITS'($urandom_range(31));
			endcase
			lim = (base == BASE_AUTO) ? 10 : (base > BASE_HEX) ? 16 : int'(base);
			repeat ($urandom_range(2))
				text_chars.push_back(WS_CHARS[$urandom_range(5)]);
			case ($urandom_range(3))
				0: text_chars.push_back(CH_MINUS);
				1: text_chars.push_back(CH_PLUS);
				default: ;
			endcase
			if (base inside {BASE_AUTO, BASE_HEX} && $urandom_range(2) == 0) begin
				text_chars.push_back(CH_ZERO);
				if ($urandom_range(1)) begin
					text_chars.push_back($urandom_range(1) ? CH_LX : CH_UX);
					lim = 16;
				end else if (base == BASE_AUTO) begin
					lim = 8;
				end
			end
			n = ($urandom_range(3) == 0) ? $urandom_range(9, 14) : $urandom_range(6);
			repeat (n) begin
				d = $urandom_range(lim - 1);
				if (d < 10)
					text_chars.push_back(CH_ZERO + 8'(d));
				else
					text_chars.push_back(($urandom_range(1) ? CH_UA : CH_LA) + 8'(d - 10));
			end
			pick = $urandom_range(19);
			if (pick >= 5)
				text_chars.push_back(CH_NUL);
			else if (pick != 0)
				text_chars.push_back(8'($urandom_range(255)));
			// pick == 0 leaves the string open for the next start to drop
			if (text_chars.size() == 0)
				text_chars.push_back(CH_NUL);
			foreach (text_chars[i])
				push_beat(text_chars[i], i == 0, i == 0 ? base : BASE_BITS'($urandom_range(31)));
			random_chars += text_chars.size();
		end

		repeat (2) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		wait (chars_taken == chars_queued);
		while (expected_conversions.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (mismatches == 0 && expected_conversions.size() == 0)
			$display("tb_string_to_unsigned_integer OK");
		else
			$display("tb_string_to_unsigned_integer NOT OK");
		$finish;
	end

endmodule
